FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared opcodes, status codes and controller/datapath handshake structs for
// the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// Hash width and the multiply, multiply-back and correct steps of the
	// start-slot reduction
	localparam int HASH_BITS     = 32;
	localparam int MOD_STEPS     = 3;

	typedef struct packed {
		logic load;         // capture request fields
		logic mod_step;     // advance start-slot reduction
		logic probe_start;  // read the start slot
		logic advance;      // read the next slot
		logic finish;       // commit write, count and result
		logic clear_step;   // clear one row after reset
	} cmd_t;

	typedef struct packed {
		logic mod_done;     // start slot ready
		logic probe_done;   // current slot decides the request
		logic out_free;     // result register can take a result
		logic clear_last;   // last row of the clearing pass
	} sts_t;

endpackage

FILE: rtl/lpht_mem.sv
// ----------------------------------------------------------------------------
// lpht_mem
// Slot storage: one write port and one registered read port. Each row holds
// the occupied flag, the key and the value.
// ----------------------------------------------------------------------------
module lpht_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 129
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read row, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: clearing pass after reset, request capture, start-slot
// reduction, slot-by-slot probing and commit.
// ----------------------------------------------------------------------------
module lpht_ctrl
	import lpht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_CHECK
	} state_t;

	state_t state_q;

	// Hold off requests outside idle
	assign in_stall = (state_q != S_IDLE);

	// Decode commands
	always_comb begin
		cmd             = '0;
		cmd.clear_step  = (state_q == S_CLEAR);
		cmd.load        = (state_q == S_IDLE) && in_valid;
		cmd.mod_step    = (state_q == S_MOD) && !sts.mod_done;
		cmd.probe_start = (state_q == S_MOD) && sts.mod_done;
		cmd.advance     = (state_q == S_CHECK) && !sts.probe_done;
		cmd.finish      = (state_q == S_CHECK) && sts.probe_done && sts.out_free;
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_MOD;
				end
				S_MOD: begin
					if (sts.mod_done) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cmd.finish) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_MOD))
		else $error("accepted transaction did not start reduction");
	a_no_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!cmd.load && !cmd.finish))
		else $error("transaction activity during clearing pass");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE))
		else $error("commit did not return to idle");
	a_wait_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHECK) && sts.probe_done && !sts.out_free) |=>
		(state_q == S_CHECK))
		else $error("decided probe left while result register busy");
`endif

endmodule

FILE: rtl/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: request registers, start-slot reduction, probe address and
// counter, slot compare, commit write, entry count and result register.
// ----------------------------------------------------------------------------
module lpht_dp
	import lpht_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cmd_t                               cmd,
	output sts_t                               sts,
	input  logic [1:0]                         opcode,
	input  logic [63:0]                        key,
	input  logic [31:0]                        key_hash,
	input  logic [63:0]                        value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic [63:0]                        value_out,
	output logic [4:0]                         slot_index,
	output logic [5:0]                         entry_count,
	output logic                               mem_we,
	output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
	output logic [KEY_BITS+VALUE_BITS:0]       mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
	input  logic [KEY_BITS+VALUE_BITS:0]       mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         probe_cnt_q;
	logic [AW-1:0]         clr_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         start_slot;
	logic                  mod_done;

	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [63:0]           value_out_q;
	logic [4:0]            slot_q;
	logic [5:0]            count_out_q;

	// Row fields
	logic                  rd_occ;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  key_match;
	logic                  last_probe;
	logic [AW-1:0]         next_idx;

	// Probe decision
	logic                  done;
	logic [2:0]            res_status;
	logic [63:0]           res_value;
	logic                  res_touch;
	logic                  res_write;
	logic [KEY_BITS+VALUE_BITS:0] res_row;
	logic [CW-1:0]         count_next;
	logic [31:0]           slot_ext;
	logic [31:0]           count_ext;

	// Start slot: mask for power-of-two capacity, else reciprocal multiply,
	// multiply back and one conditional subtract
	generate
		if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
			logic [AW-1:0] hash_low_q;

			always_ff @(posedge clk) begin
				if (cmd.load) hash_low_q <= key_hash[AW-1:0];
			end

			assign start_slot = hash_low_q;
			assign mod_done   = 1'b1;
		end else begin : g_rem
			localparam int SW = $clog2(MOD_STEPS + 1);
			localparam int SH = HASH_BITS + AW;
			localparam int PW = 2 * HASH_BITS + 1;
			localparam int QW = HASH_BITS + 1 - AW;
			localparam logic [HASH_BITS:0] RECIP =
				(HASH_BITS+1)'((64'd1 << SH) / 64'(CAPACITY));
			localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);
			logic [HASH_BITS-1:0] hash_q;
			logic [PW-1:0]        prod_q;
			logic [AW:0]          diff_q;
			logic [AW-1:0]        rem_q;
			logic [SW-1:0]        step_q;
			logic [QW-1:0]        quo;

			// Quotient estimate, low by at most one
			assign quo = prod_q[PW-1:SH];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
				end else if (cmd.load) begin
					step_q <= '0;
				end else if (cmd.mod_step) begin
					step_q <= step_q + 1'b1;
				end
			end

			// Multiply by the reciprocal, subtract the product back, correct once
			always_ff @(posedge clk) begin
				if (cmd.load) begin
					hash_q <= key_hash;
				end else if (cmd.mod_step) begin
					case (step_q)
						SW'(0): begin
							prod_q <= hash_q * RECIP;
						end
						SW'(1): begin
							diff_q <= (AW+1)'(hash_q -
								HASH_BITS'(quo) * HASH_BITS'(CAPACITY));
						end
						SW'(2): begin
							rem_q <= (diff_q >= CAP_W) ? AW'(diff_q - CAP_W) :
								diff_q[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end

			assign start_slot = rem_q;
			assign mod_done   = (step_q == SW'(MOD_STEPS));
		end
	endgenerate

	assign rd_occ     = mem_rdata[KEY_BITS+VALUE_BITS];
	assign rd_key     = mem_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
	assign rd_val     = mem_rdata[VALUE_BITS-1:0];
	assign key_match  = rd_occ && (rd_key == key_q);
	assign last_probe = (probe_cnt_q == LAST_SLOT);
	assign next_idx   = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	// Decide on the slot now in the read register
	always_comb begin
		done       = 1'b0;
		res_status = ST_NOT_FOUND;
		res_value  = '0;
		res_touch  = 1'b0;
		res_write  = 1'b0;
		res_row    = {1'b1, key_q, val_q};
		count_next = count_q;
		case (op_q)
			OP_INSERT: begin
				if (key_match) begin
					done       = 1'b1;
					res_status = ST_UPDATED;
					res_touch  = 1'b1;
					res_write  = 1'b1;
				end else if (!rd_occ) begin
					done       = 1'b1;
					res_status = ST_INSERTED;
					res_touch  = 1'b1;
					res_write  = 1'b1;
					count_next = count_q + 1'b1;
				end else if (last_probe) begin
					done       = 1'b1;
					res_status = ST_FULL;
				end
			end
			OP_LOOKUP, OP_REMOVE: begin
				if (!rd_occ) begin
					done = 1'b1;
				end else if (key_match) begin
					done      = 1'b1;
					res_touch = 1'b1;
					res_value = 64'(rd_val);
					if (op_q == OP_LOOKUP) begin
						res_status = ST_FOUND;
					end else begin
						res_status = ST_REMOVED;
						res_write  = 1'b1;
						res_row    = {1'b0, rd_key, rd_val};
						if (count_q != '0) count_next = count_q - 1'b1;
					end
				end else if (last_probe) begin
					done = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign slot_ext  = 32'(res_touch ? idx_q : '0);
	assign count_ext = 32'(count_next);

	// Select read address: start slot, next slot, or hold the current one
	always_comb begin
		if (cmd.probe_start) begin
			mem_raddr = start_slot;
		end else if (cmd.advance) begin
			mem_raddr = next_idx;
		end else begin
			mem_raddr = idx_q;
		end
	end

	// Write port: clearing pass or commit
	always_comb begin
		if (cmd.clear_step) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = cmd.finish && res_write;
			mem_waddr = idx_q;
			mem_wdata = res_row;
		end
	end

	// Capture request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(opcode);
			key_q <= key[KEY_BITS-1:0];
			val_q <= value[VALUE_BITS-1:0];
		end
	end

	// Track probe slot, probe count, clearing pointer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			probe_cnt_q <= '0;
			clr_q       <= '0;
			count_q     <= '0;
		end else begin
			if (cmd.probe_start) begin
				idx_q       <= start_slot;
				probe_cnt_q <= '0;
			end else if (cmd.advance) begin
				idx_q       <= next_idx;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.finish) count_q <= count_next;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= res_status;
			value_out_q <= res_value;
			slot_q      <= slot_ext[4:0];
			count_out_q <= count_ext[5:0];
		end
	end

	assign sts.mod_done   = mod_done;
	assign sts.probe_done = done;
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.clear_last = (clr_q == LAST_SLOT);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign slot_index  = slot_q;
	assign entry_count = count_out_q;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// Flow: an accepted request passes the start-slot reduction (multiply, multiply
//   back, correct; a mask when CAPACITY is a power of two), then probes one slot
//   per cycle through the single read port of the slot memory, up to CAPACITY
//   slots; a new request is accepted only after the previous one is committed.
// Reset: asynchronous, active low; a clearing pass over every row follows,
//   during which no transaction is accepted.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert/update, lookup and
// remove without tombstones, one result per request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key,
	input  logic [31:0] key_hash,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [63:0] value_out,
	output logic [4:0]  slot_index,
	output logic [5:0]  entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int RW = 1 + KEY_BITS + VALUE_BITS;

	cmd_t          cmd;
	sts_t          sts;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [RW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [RW-1:0] mem_rdata;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpht_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.key         (key),
		.key_hash    (key_hash),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.value_out   (value_out),
		.slot_index  (slot_index),
		.entry_count (entry_count),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	lpht_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (RW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
